FILE: rtl/core/gcc_pkg.sv
package gcc_pkg;

    // Number of coin registers in use, from 1 to MAX_COINS.
    localparam int NUM_COINS = 5;
    localparam int MAX_COINS = 5;

    localparam int AMOUNT_W  = 16;
    localparam int IDX_W     = 3;
    localparam int DIV_STEPS = AMOUNT_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef logic [AMOUNT_W-1:0] amount_t;
    typedef logic [IDX_W-1:0]    coin_idx_t;
    typedef logic [STEP_W-1:0]   step_t;

    typedef amount_t [NUM_COINS-1:0] coin_vals_t;

    localparam amount_t COIN_RESET [MAX_COINS] = '{
        16'd1000, 16'd500, 16'd200, 16'd100, 16'd50
    };

    localparam coin_idx_t LAST_IDX   = coin_idx_t'(NUM_COINS - 1);
    localparam coin_idx_t COIN_COUNT = coin_idx_t'(NUM_COINS);
    localparam step_t     LAST_STEP  = step_t'(DIV_STEPS - 1);

    // One queued request: the amount and whether it is zero.
    typedef struct packed {
        logic    is_zero;
        amount_t amount;
    } queue_entry_t;

    typedef struct packed {
        logic    start;
        amount_t dividend;
        amount_t divisor;
    } div_req_t;

    typedef struct packed {
        logic    done;
        amount_t quotient;
        amount_t remainder;
    } div_rsp_t;

endpackage

FILE: rtl/core/gcc_front.sv
module gcc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  gcc_pkg::amount_t     amount,
    output logic                 q_valid,
    input  logic                 q_ready,
    output gcc_pkg::queue_entry_t q_entry
);
    import gcc_pkg::*;

    localparam int DEPTH = 2;

    queue_entry_t mem [DEPTH];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         push;
    logic         pop;

    assign in_ready = (count_reg != 2'(DEPTH));
    assign q_valid  = (count_reg != 2'd0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_entry  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= '{is_zero: (amount == '0), amount: amount};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/core/gcc_div.sv
module gcc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  gcc_pkg::div_req_t req,
    output gcc_pkg::div_rsp_t rsp
);
    import gcc_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    step_t               cnt_reg;
    amount_t             rem_reg;
    amount_t             quo_reg;
    amount_t             div_reg;
    logic [AMOUNT_W+1:0] diff;

    // Restoring division, one quotient bit per cycle, dividend shifted out of quo_reg.
    assign diff = {1'b0, rem_reg, quo_reg[AMOUNT_W-1]} - {2'b00, div_reg};

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            div_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[AMOUNT_W+1])
            begin
                rem_reg <= diff[AMOUNT_W-1:0];
                quo_reg <= {quo_reg[AMOUNT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[AMOUNT_W-2:0], quo_reg[AMOUNT_W-1]};
                quo_reg <= {quo_reg[AMOUNT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + step_t'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/core/gcc_back.sv
module gcc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gcc_pkg::coin_vals_t   coin_vals,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  gcc_pkg::queue_entry_t q_entry,
    output gcc_pkg::div_req_t     div_req,
    input  gcc_pkg::div_rsp_t     div_rsp,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gcc_pkg::coin_idx_t    coin_index,
    output gcc_pkg::amount_t      coin_count,
    output gcc_pkg::amount_t      amount_left,
    output logic                  last
);
    import gcc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COIN,
        S_DIV,
        S_OUT
    } state_t;

    state_t    state_reg;
    coin_idx_t k_reg;
    logic      zero_reg;
    amount_t   left_reg;
    amount_t   count_reg;
    amount_t   coin;
    logic      skip;

    // A zero coin or a zero request fits no times, so no division is needed.
    assign coin = coin_vals[k_reg];
    assign skip = (coin == '0) || zero_reg;

    assign q_ready          = (state_reg == S_IDLE);
    assign div_req.start    = (state_reg == S_COIN) && !skip;
    assign div_req.dividend = left_reg;
    assign div_req.divisor  = coin;

    assign out_valid   = (state_reg == S_OUT);
    assign coin_index  = k_reg;
    assign coin_count  = count_reg;
    assign amount_left = left_reg;
    assign last        = (k_reg == LAST_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            zero_reg  <= 1'b0;
            left_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        left_reg  <= q_entry.amount;
                        zero_reg  <= q_entry.is_zero;
                        k_reg     <= '0;
                        state_reg <= S_COIN;
                    end
                end
                S_COIN:
                begin
                    if (skip)
                    begin
                        count_reg <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        count_reg <= div_rsp.quotient;
                        left_reg  <= div_rsp.remainder;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        if (k_reg == LAST_IDX)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + coin_idx_t'(1);
                            state_reg <= S_COIN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/greedy_coin_change.sv
// Greedy coin change. Each request carries an amount in hundredths and yields
// one result per coin register, in register order: the number of that coin
// handed out and the amount still left afterwards, with last set on the
// result for the final coin. A coin value of zero is skipped (count zero,
// amount unchanged). The front part takes requests into a two-entry queue and
// marks zero amounts; the back part walks the coins with one shared 16-step
// shift-subtract divider. A coin that is divided is selected, run through the
// sixteen divider steps, collected and then presented; a skipped coin is
// selected and presented. A request is first taken from the queue, and a
// stalled output holds the walk. Up to two further requests are accepted
// while one is being worked on. Coin values are written through the
// configuration port at index 0 to 4; writes to higher indexes are ignored,
// and writes are only to be made while the block is idle.
module greedy_coin_change (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gcc_pkg::amount_t    amount,
    output logic                out_valid,
    input  logic                out_ready,
    output gcc_pkg::coin_idx_t  coin_index,
    output gcc_pkg::amount_t    coin_count,
    output gcc_pkg::amount_t    amount_left,
    output logic                last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  gcc_pkg::coin_idx_t  cfg_index,
    input  gcc_pkg::amount_t    cfg_data
);
    import gcc_pkg::*;

    coin_vals_t   coin_val_reg;
    logic         q_valid;
    logic         q_ready;
    queue_entry_t q_entry;
    div_req_t     div_req;
    div_rsp_t     div_rsp;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COINS; i++)
            begin
                coin_val_reg[i] <= COIN_RESET[i];
            end
        end
        else if (cfg_valid && (cfg_index < COIN_COUNT))
        begin
            coin_val_reg[cfg_index] <= cfg_data;
        end
    end

    gcc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .amount   (amount),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_entry  (q_entry)
    );

    gcc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    gcc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .coin_vals   (coin_val_reg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_entry     (q_entry),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .coin_index  (coin_index),
        .coin_count  (coin_count),
        .amount_left (amount_left),
        .last        (last)
    );

endmodule

FILE: rtl/core/gcc_checker.sv
module gcc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input gcc_pkg::coin_idx_t  coin_index,
    input gcc_pkg::amount_t    coin_count,
    input gcc_pkg::amount_t    amount_left,
    input logic                last
);
    import gcc_pkg::*;

    // A stalled result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(coin_index)
            && $stable(coin_count) && $stable(amount_left) && $stable(last))
    else $error("result changed while stalled");

    // The final coin is the only one marked last.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (coin_index == LAST_IDX)))
    else $error("last does not match the final coin");

    // Coin indexes stay within the configured coins.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (coin_index < COIN_COUNT))
    else $error("coin index out of range");

    // No result is presented in the cycle after one is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
    else $error("result presented back to back");

endmodule

bind greedy_coin_change gcc_checker u_gcc_checker (.*);

FILE: test/coin_change_checker.sv
`timescale 1ns / 100ps

module coin_change_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  gcc_pkg::amount_t   amount,
    input  logic               out_valid,
    input  logic               out_ready,
    input  gcc_pkg::coin_idx_t coin_index,
    input  gcc_pkg::amount_t   coin_count,
    input  gcc_pkg::amount_t   amount_left,
    input  logic               last,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  gcc_pkg::coin_idx_t cfg_index,
    input  gcc_pkg::amount_t   cfg_data,
    output int                 failures,
    output int                 pending,
    output int                 results_checked
);

    import gcc_pkg::*;

    typedef struct packed {
        coin_idx_t index;
        amount_t   count;
        amount_t   left;
        logic      last;
    } coin_result_t;

    amount_t      coin_value [MAX_COINS];
    coin_result_t due_results [$];
    coin_result_t want;
    int           fail_count;
    int           seen_count;

    // Walks the coins in register order; a zero coin fits no times.
    function automatic void split_amount(input amount_t amt);
        amount_t      rest;
        amount_t      count;
        int           n;
        coin_result_t r;
        rest = amt;
        n = (NUM_COINS > MAX_COINS) ? MAX_COINS : NUM_COINS;
        for (int k = 0; k < n; k++) begin
            count = '0;
            if (coin_value[k] != '0) begin
                count = rest / coin_value[k];
                rest  = rest % coin_value[k];
            end
            r.index = coin_idx_t'(k);
            r.count = count;
            r.left  = rest;
            r.last  = (k == n - 1);
            due_results.push_back(r);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int k = 0; k < MAX_COINS; k++) begin
                coin_value[k] = COIN_RESET[k];
            end
            due_results.delete();
            pending <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                seen_count++;
                if (due_results.size() == 0) begin
                    $error("unexpected result: coin_index %0d coin_count %0d amount_left %0d",
                           coin_index, coin_count, amount_left);
                    fail_count++;
                end
                else begin
                    want = due_results.pop_front();
                    if (coin_index !== want.index) begin
                        $error("coin_index: expected %0d, actual %0d", want.index, coin_index);
                        fail_count++;
                    end
                    if (coin_count !== want.count) begin
                        $error("coin_count: expected %0d, actual %0d", want.count, coin_count);
                        fail_count++;
                    end
                    if (amount_left !== want.left) begin
                        $error("amount_left: expected %0d, actual %0d", want.left, amount_left);
                        fail_count++;
                    end
                    if (last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, last);
                        fail_count++;
                    end
                end
            end
            // Writes to indexes past the register list are dropped.
            if (cfg_valid && cfg_ready && cfg_index < MAX_COINS) begin
                coin_value[cfg_index] = cfg_data;
            end
            if (in_valid && in_ready) begin
                split_amount(amount);
            end
            pending         <= due_results.size();
            failures        <= fail_count;
            results_checked <= seen_count;
        end
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;

    import gcc_pkg::*;

    // The run is bounded by this many clock cycles. A correct run ends before
    // it, even with every stall and the long hold-off.
    localparam int LIMIT_CYCLES = 500000;
    // Length of the single long hold-off on the result side.
    localparam int HOLD_CYCLES  = 600;
    // Cycles to keep watching after the last result.
    localparam int TAIL_CYCLES  = 200;
    // The first register index that lies beyond the coin list.
    localparam int STRAY_FIRST  = MAX_COINS;
    localparam int STRAY_END    = 1 << IDX_W;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    amount_t   amount;
    logic      out_valid;
    logic      out_ready;
    coin_idx_t coin_index;
    amount_t   coin_count;
    amount_t   amount_left;
    logic      last;
    logic      cfg_valid;
    logic      cfg_ready;
    coin_idx_t cfg_index;
    amount_t   cfg_data;

    int failures;
    int pending;
    int results_checked;

    int cycles;
    int requests_sent;
    int settings_used;
    bit calm;
    bit hold_pending;

    // The coin values currently loaded, so that amounts can be aimed at them.
    amount_t plan [MAX_COINS];

    // Amounts for the directed part at the reset coin values: the range ends,
    // alternating bit patterns, values just below and at the coins 50, 100 and
    // 1000, and a sum that uses every coin once.
    amount_t corner_amounts [18] = '{
        16'd0, 16'd1, 16'd49, 16'd50, 16'd99, 16'd100, 16'd999, 16'd1000,
        16'd1850, 16'd1899, 16'd3000, 16'd1750, 16'hFFFF, 16'hFFFE,
        16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555
    };

    greedy_coin_change dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .amount      (amount),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .coin_index  (coin_index),
        .coin_count  (coin_count),
        .amount_left (amount_left),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // The checker sits beside the block, watches all three channels, predicts
    // the coin results of every accepted request and compares them.
    coin_change_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .amount          (amount),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .coin_index      (coin_index),
        .coin_count      (coin_count),
        .amount_left     (amount_left),
        .last            (last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .failures        (failures),
        .pending         (pending),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog. If the run has not ended by the limit, something hangs.
    initial
    begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // Result side. Ready drops in about a third of the cycles, except in the
    // calm phase. When the stimulus asks for it, ready is held low for a long
    // stretch so that the request queue fills and the input stalls. The
    // stretch is counted here, independently of the request side.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pending = 1'b0;
            end
            out_ready <= calm || ($urandom_range(0, 99) >= 34);
        end
    end

    // Offers one request and returns once it has been accepted. Outside the
    // calm phase a short gap with valid low comes first, about a third of the
    // time. Valid is never lowered here after acceptance, so back-to-back
    // requests keep it high without a glitch.
    task automatic offer_amount(input amount_t a);
        int gap;
        if (!calm && $urandom_range(0, 99) < 34)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        amount   <= a;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        requests_sent++;
    endtask

    // Lowers valid and waits until the checker holds no expected results.
    // The count that the checker reports is registered, hence the first
    // edge before it is looked at.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_coin_reg(input int idx, input amount_t data);
        cfg_valid <= 1'b1;
        cfg_index <= coin_idx_t'(idx);
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Loads the whole plan into the block. With strays set, writes to every
    // index past the list follow; the block must drop them.
    task automatic load_plan(input bit strays);
        for (int r = 0; r < MAX_COINS; r++)
        begin
            write_coin_reg(r, plan[r]);
        end
        if (strays)
        begin
            for (int r = STRAY_FIRST; r < STRAY_END; r++)
            begin
                write_coin_reg(r, amount_t'($urandom_range(1, 65535)));
            end
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // A coin value for a random setting: sometimes zero, often small so that
    // counts get large, mostly up to 2000, and now and then anywhere in the range.
    function automatic amount_t pick_coin();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        else if (sel < 3)
            return amount_t'($urandom_range(1, 16));
        else if (sel == 3)
            return amount_t'($urandom_range(1, 65535));
        else
            return amount_t'($urandom_range(1, 2000));
    endfunction

    // A request amount: uniform over the whole range, small, or aimed at a
    // multiple of one of the loaded coins, one below, at or one above it.
    function automatic amount_t pick_amount();
        int unsigned sel;
        int unsigned k;
        int          v;
        sel = $urandom_range(0, 9);
        k   = $urandom_range(0, MAX_COINS - 1);
        if (sel < 4)
            v = $urandom_range(0, 65535);
        else if (sel < 7)
            v = $urandom_range(0, 4000);
        else
            v = int'(plan[k]) * $urandom_range(0, 8) + $urandom_range(0, 2) - 1;
        return amount_t'(v);
    endfunction

    task automatic random_requests(input int n);
        for (int i = 0; i < n; i++)
        begin
            offer_amount(pick_amount());
        end
    endtask

    task automatic random_plan();
        for (int r = 0; r < MAX_COINS; r++)
        begin
            plan[r] = pick_coin();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        amount        = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        calm          = 1'b0;
        hold_pending  = 1'b0;
        requests_sent = 0;
        settings_used = 1;
        for (int r = 0; r < MAX_COINS; r++)
        begin
            plan[r] = COIN_RESET[r];
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset coin values: directed corners first, then random requests.
        foreach (corner_amounts[i])
        begin
            offer_amount(corner_amounts[i]);
        end
        random_requests(80);
        drain();

        // Every coin worth one hundredth: the first coin takes everything.
        foreach (plan[r]) plan[r] = 16'd1;
        load_plan(1'b0);
        offer_amount(16'hFFFF);
        offer_amount(16'd0);
        random_requests(40);
        drain();

        // Every coin at the largest value: almost nothing fits.
        foreach (plan[r]) plan[r] = 16'hFFFF;
        load_plan(1'b0);
        offer_amount(16'hFFFF);
        offer_amount(16'hFFFE);
        random_requests(40);
        drain();

        // Zero coins mixed in, including the final one, with stray writes to
        // indexes past the list that must leave these values in place.
        plan[0] = 16'd0;
        plan[1] = 16'd700;
        plan[2] = 16'd0;
        plan[3] = 16'd30;
        plan[4] = 16'd0;
        load_plan(1'b1);
        offer_amount(16'hFFFF);
        random_requests(40);
        drain();

        // Smallest coin first, so later coins never get anything.
        plan[0] = 16'd50;
        plan[1] = 16'd100;
        plan[2] = 16'd200;
        plan[3] = 16'd500;
        plan[4] = 16'd1000;
        load_plan(1'b0);
        random_requests(40);
        drain();

        // Calm phase: no idling on either side, requests back to back.
        random_plan();
        load_plan(1'b0);
        calm = 1'b1;
        random_requests(60);
        drain();
        calm = 1'b0;

        // The result side holds off for a long stretch while requests keep
        // coming, so the block fills up and stalls its input.
        random_plan();
        load_plan(1'b1);
        hold_pending = 1'b1;
        random_requests(80);
        drain();

        // A few more random settings.
        for (int p = 0; p < 3; p++)
        begin
            random_plan();
            load_plan(1'b0);
            random_requests(35);
            drain();
        end

        // Anything the block emits from here on is unexpected and counts.
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d change requests over %0d coin settings; %0d coin results checked.",
                 requests_sent, settings_used, results_checked);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
